>>> sv/msgpack_map_key_extractor_core_assert.svh
// Assertion macros shared by the MessagePack map key extractor RTL.
// Depends on nothing; each macro expands to nothing when SYNTH is defined.
`ifndef MSGPACK_MAP_KEY_EXTRACTOR_CORE_ASSERT_SVH
`define MSGPACK_MAP_KEY_EXTRACTOR_CORE_ASSERT_SVH

`ifndef SYNTH
// The expression holds at every clock edge outside reset.
`define MMKE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// The consequent holds in the same cycle as the antecedent.
`define MMKE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define MMKE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MMKE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define MMKE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define MMKE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> sv/mmke_pkg.sv
// Shared types and constants of the MessagePack map key extractor.
// Used by the parser, the result queue and the top level; depends on nothing.
`default_nettype none

package mmke_pkg;

    // Key storage: four 64-bit registers, first byte in the lowest bits.
    localparam int unsigned KEY_REGS         = 4;
    localparam int unsigned KEY_REG_W        = 64;
    localparam int unsigned KEY_BITS         = KEY_REGS * KEY_REG_W;
    localparam int unsigned KEY_REG_BYTES    = KEY_BITS / 8;
    localparam int unsigned KEY_MAX_BYTES_DEF = 32;
    localparam int unsigned KEY_LEN_W        = 6;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_3 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_WANT_STRING = 3'd5;

    // MessagePack markers.
    localparam logic [3:0] MP_FIXMAP_HI = 4'h8;
    localparam logic [7:0] MP_MAP16     = 8'hde;
    localparam logic [2:0] MP_FIXSTR_HI = 3'b101;
    localparam logic [7:0] MP_STR8      = 8'hd9;
    localparam logic [7:0] MP_STR16     = 8'hda;
    localparam logic [7:0] MP_UINT8     = 8'hcc;
    localparam logic [7:0] MP_UINT16    = 8'hcd;
    localparam logic [7:0] MP_UINT32    = 8'hce;
    localparam logic [7:0] MP_UINT64    = 8'hcf;
    localparam logic [7:0] MP_NIL       = 8'hc0;
    localparam logic [7:0] MP_FALSE     = 8'hc2;
    localparam logic [7:0] MP_TRUE      = 8'hc3;

    localparam int unsigned PAYLOAD_W = 64;

    // Result queue.
    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = 2;
    localparam int unsigned RES_CNT_W = 3;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_FOUND     = 2'd1,
        KIND_NOT_FOUND = 2'd2,
        KIND_MALFORMED = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [PAYLOAD_W-1:0] payload;
    } res_t;

    // Results of one accepted byte: res0 first, then res1.
    typedef struct packed {
        logic [1:0] cnt;
        res_t       res0;
        res_t       res1;
    } push_t;

endpackage

`default_nettype wire

>>> sv/mmke_parser.sv
// Byte-wise MessagePack map parser: tracks the walk through the map and
// produces up to two results per byte. Depends on mmke_pkg and the assert macros.
`default_nettype none
`include "msgpack_map_key_extractor_core_assert.svh"

module mmke_parser #(
    parameter int unsigned KEY_MAX_BYTES = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               accept,
    input  wire logic [7:0]                         in_byte,
    input  wire logic                               end_of_buffer,
    input  wire logic [mmke_pkg::KEY_LEN_W-1:0]     key_length,
    input  wire logic [mmke_pkg::KEY_BITS-1:0]      key_bits,
    input  wire logic                               want_string,
    output mmke_pkg::push_t                         push
);

    import mmke_pkg::*;

    localparam int unsigned KPOS_W = $clog2(KEY_MAX_BYTES + 1);

    typedef enum logic [3:0] {
        PH_MAP_HDR, PH_MAP_HI, PH_MAP_LO, PH_KEY_HDR, PH_KEY_LEN8, PH_KEY_HI,
        PH_KEY_LO, PH_KEY_BODY, PH_VAL_HDR, PH_VAL_INT, PH_VAL_LEN8, PH_VAL_HI,
        PH_VAL_LO, PH_STR_OUT, PH_SKIP
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [15:0]           pairs_left_reg, pairs_left_next;
    logic [15:0]           bytes_left_reg, bytes_left_next;
    logic [KPOS_W-1:0]     key_pos_reg, key_pos_next;
    logic                  key_match_reg, key_match_next;
    logic [PAYLOAD_W-1:0]  acc_reg, acc_next;
    logic                  decided_reg, decided_next;

    logic [15:0]           bytes_dec;
    logic [15:0]           pairs_dec;
    logic [6:0]            pos_ext;
    logic [7:0]            key_byte;
    logic                  do_start_key;
    logic [15:0]           start_key_len;
    logic                  do_start_str;
    logic [15:0]           start_str_len;
    logic                  do_pair_done;
    logic                  emit_byte;
    logic                  st_valid;
    kind_t                 st_kind;
    logic [PAYLOAD_W-1:0]  st_payload;
    logic                  trunc;
    logic                  stat_any;
    res_t                  stat_res;

    assign bytes_dec = bytes_left_reg - 16'd1;
    assign pairs_dec = pairs_left_reg - 16'd1;
    assign pos_ext   = 7'(key_pos_reg);
    // Key bytes past the stored key read as zero.
    assign key_byte  = (pos_ext < 7'(KEY_REG_BYTES))
                     ? key_bits[{pos_ext[4:0], 3'b000} +: 8] : 8'h00;

    always_comb
    begin
        phase_next      = phase_reg;
        pairs_left_next = pairs_left_reg;
        bytes_left_next = bytes_left_reg;
        key_pos_next    = key_pos_reg;
        key_match_next  = key_match_reg;
        acc_next        = acc_reg;
        decided_next    = decided_reg;
        do_start_key    = 1'b0;
        start_key_len   = 16'd0;
        do_start_str    = 1'b0;
        start_str_len   = 16'd0;
        do_pair_done    = 1'b0;
        emit_byte       = 1'b0;
        st_valid        = 1'b0;
        st_kind         = KIND_MALFORMED;
        st_payload      = '0;

        if (!decided_reg)
        begin
            unique case (phase_reg)
                PH_MAP_HDR:
                begin
                    priority if (in_byte[7:4] == MP_FIXMAP_HI)
                    begin
                        pairs_left_next = {12'd0, in_byte[3:0]};
                        if (in_byte[3:0] == 4'd0)
                        begin
                            st_valid = 1'b1;
                            st_kind  = KIND_NOT_FOUND;
                        end
                        else
                        begin
                            phase_next = PH_KEY_HDR;
                        end
                    end
                    else if (in_byte == MP_MAP16)
                    begin
                        phase_next = PH_MAP_HI;
                    end
                    else
                    begin
                        st_valid = 1'b1;
                    end
                end
                PH_MAP_HI:
                begin
                    pairs_left_next = {in_byte, 8'd0};
                    phase_next      = PH_MAP_LO;
                end
                PH_MAP_LO:
                begin
                    pairs_left_next = pairs_left_reg | {8'd0, in_byte};
                    if ((pairs_left_reg | {8'd0, in_byte}) == 16'd0)
                    begin
                        st_valid = 1'b1;
                        st_kind  = KIND_NOT_FOUND;
                    end
                    else
                    begin
                        phase_next = PH_KEY_HDR;
                    end
                end
                PH_KEY_HDR:
                begin
                    priority if (in_byte[7:5] == MP_FIXSTR_HI)
                    begin
                        do_start_key  = 1'b1;
                        start_key_len = {11'd0, in_byte[4:0]};
                    end
                    else if (in_byte == MP_STR8)
                    begin
                        phase_next = PH_KEY_LEN8;
                    end
                    else if (in_byte == MP_STR16)
                    begin
                        phase_next = PH_KEY_HI;
                    end
                    else
                    begin
                        st_valid = 1'b1;
                    end
                end
                PH_KEY_LEN8:
                begin
                    do_start_key  = 1'b1;
                    start_key_len = {8'd0, in_byte};
                end
                PH_KEY_HI:
                begin
                    bytes_left_next = {in_byte, 8'd0};
                    phase_next      = PH_KEY_LO;
                end
                PH_KEY_LO:
                begin
                    do_start_key  = 1'b1;
                    start_key_len = bytes_left_reg | {8'd0, in_byte};
                end
                PH_KEY_BODY:
                begin
                    if (key_match_reg && (key_byte != in_byte))
                    begin
                        key_match_next = 1'b0;
                    end
                    key_pos_next    = key_pos_reg + KPOS_W'(1);
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 16'd0)
                    begin
                        phase_next = PH_VAL_HDR;
                    end
                end
                PH_VAL_HDR:
                begin
                    priority if (!in_byte[7])
                    begin
                        if (!want_string && key_match_reg)
                        begin
                            st_valid   = 1'b1;
                            st_kind    = KIND_FOUND;
                            st_payload = {56'd0, in_byte};
                        end
                        else
                        begin
                            do_pair_done = 1'b1;
                        end
                    end
                    else if (in_byte == MP_UINT8)
                    begin
                        bytes_left_next = 16'd1;
                        acc_next        = '0;
                        phase_next      = PH_VAL_INT;
                    end
                    else if (in_byte == MP_UINT16)
                    begin
                        bytes_left_next = 16'd2;
                        acc_next        = '0;
                        phase_next      = PH_VAL_INT;
                    end
                    else if (in_byte == MP_UINT32)
                    begin
                        bytes_left_next = 16'd4;
                        acc_next        = '0;
                        phase_next      = PH_VAL_INT;
                    end
                    else if (in_byte == MP_UINT64)
                    begin
                        bytes_left_next = 16'd8;
                        acc_next        = '0;
                        phase_next      = PH_VAL_INT;
                    end
                    else if (in_byte[7:5] == MP_FIXSTR_HI)
                    begin
                        do_start_str  = 1'b1;
                        start_str_len = {11'd0, in_byte[4:0]};
                    end
                    else if (in_byte == MP_STR8)
                    begin
                        phase_next = PH_VAL_LEN8;
                    end
                    else if (in_byte == MP_STR16)
                    begin
                        phase_next = PH_VAL_HI;
                    end
                    else if (want_string && ((in_byte == MP_NIL) || (in_byte == MP_FALSE)
                                             || (in_byte == MP_TRUE)))
                    begin
                        do_pair_done = 1'b1;
                    end
                    else
                    begin
                        st_valid = 1'b1;
                    end
                end
                PH_VAL_INT:
                begin
                    acc_next        = {acc_reg[PAYLOAD_W-9:0], in_byte};
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 16'd0)
                    begin
                        if (!want_string && key_match_reg)
                        begin
                            st_valid   = 1'b1;
                            st_kind    = KIND_FOUND;
                            st_payload = {acc_reg[PAYLOAD_W-9:0], in_byte};
                        end
                        else
                        begin
                            do_pair_done = 1'b1;
                        end
                    end
                end
                PH_VAL_LEN8:
                begin
                    do_start_str  = 1'b1;
                    start_str_len = {8'd0, in_byte};
                end
                PH_VAL_HI:
                begin
                    bytes_left_next = {in_byte, 8'd0};
                    phase_next      = PH_VAL_LO;
                end
                PH_VAL_LO:
                begin
                    do_start_str  = 1'b1;
                    start_str_len = bytes_left_reg | {8'd0, in_byte};
                end
                PH_STR_OUT:
                begin
                    emit_byte       = 1'b1;
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 16'd0)
                    begin
                        st_valid = 1'b1;
                        st_kind  = KIND_FOUND;
                    end
                end
                PH_SKIP:
                begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 16'd0)
                    begin
                        do_pair_done = 1'b1;
                    end
                end
                default:
                begin
                    st_valid = 1'b1;
                end
            endcase
        end

        if (do_start_key)
        begin
            key_pos_next    = '0;
            key_match_next  = (start_key_len == {10'd0, key_length})
                           && (start_key_len <= 16'(KEY_MAX_BYTES));
            bytes_left_next = start_key_len;
            phase_next      = (start_key_len == 16'd0) ? PH_VAL_HDR : PH_KEY_BODY;
        end

        if (do_start_str)
        begin
            if (want_string && key_match_reg)
            begin
                if (start_str_len == 16'd0)
                begin
                    st_valid = 1'b1;
                    st_kind  = KIND_FOUND;
                end
                else
                begin
                    bytes_left_next = start_str_len;
                    phase_next      = PH_STR_OUT;
                end
            end
            else if (start_str_len == 16'd0)
            begin
                do_pair_done = 1'b1;
            end
            else
            begin
                bytes_left_next = start_str_len;
                phase_next      = PH_SKIP;
            end
        end

        if (do_pair_done)
        begin
            pairs_left_next = pairs_dec;
            if (pairs_dec == 16'd0)
            begin
                st_valid = 1'b1;
                st_kind  = KIND_NOT_FOUND;
            end
            else
            begin
                phase_next = PH_KEY_HDR;
            end
        end

        if (st_valid)
        begin
            decided_next = 1'b1;
        end

        // A buffer that ends before any status closes as malformed.
        trunc = end_of_buffer && !decided_reg && !st_valid;

        if (end_of_buffer)
        begin
            phase_next      = PH_MAP_HDR;
            pairs_left_next = '0;
            bytes_left_next = '0;
            key_pos_next    = '0;
            key_match_next  = 1'b0;
            acc_next        = '0;
            decided_next    = 1'b0;
        end
    end

    assign stat_any         = st_valid || trunc;
    assign stat_res.kind    = st_valid ? st_kind : KIND_MALFORMED;
    assign stat_res.payload = st_valid ? st_payload : '0;

    always_comb
    begin
        push.cnt  = accept ? (2'(emit_byte) + 2'(stat_any)) : 2'd0;
        push.res1 = stat_res;
        if (emit_byte)
        begin
            push.res0.kind    = KIND_BYTE;
            push.res0.payload = {56'd0, in_byte};
        end
        else
        begin
            push.res0 = stat_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAP_HDR;
            pairs_left_reg <= '0;
            bytes_left_reg <= '0;
            key_pos_reg    <= '0;
            key_match_reg  <= 1'b0;
            acc_reg        <= '0;
            decided_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            pairs_left_reg <= pairs_left_next;
            bytes_left_reg <= bytes_left_next;
            key_pos_reg    <= key_pos_next;
            key_match_reg  <= key_match_next;
            acc_reg        <= acc_next;
            decided_reg    <= decided_next;
        end
    end

    `MMKE_ASSERT_IMPLY(a_quiet_after_status, clk, rst_n, accept && decided_reg && !end_of_buffer, push.cnt == 2'd0, "byte after status produced a result")
    `MMKE_ASSERT_IMPLY(a_last_byte_closes, clk, rst_n, accept && !decided_reg && end_of_buffer, push.cnt != 2'd0, "undecided buffer ended without a status")
    `MMKE_ASSERT_NEXT(a_clear_on_last, clk, rst_n, accept && end_of_buffer, (phase_reg == PH_MAP_HDR) && !decided_reg && (pairs_left_reg == 16'd0), "parser not cleared after last byte")

endmodule

`default_nettype wire

>>> sv/mmke_result_fifo.sv
// Four-entry result queue between the parser and the output channel.
// Takes up to two results per cycle and gives one while out_stall is low. Depends on mmke_pkg and the assert macros.
`default_nettype none
`include "msgpack_map_key_extractor_core_assert.svh"

module mmke_result_fifo (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mmke_pkg::push_t                    push,
    output logic                                    full,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output mmke_pkg::res_t                          head
);

    import mmke_pkg::*;

    res_t                 slot_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] head_reg;
    logic [RES_PTR_W-1:0] head_next;
    logic [RES_CNT_W-1:0] count_reg;
    logic [RES_CNT_W-1:0] count_next;
    logic [RES_PTR_W-1:0] tail0;
    logic [RES_PTR_W-1:0] tail1;
    logic                 pop;

    // Room for two more results is needed before a byte may be accepted.
    assign full      = count_reg > 3'(RES_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign pop       = out_valid && !out_stall;
    assign head      = slot_reg[head_reg];

    assign tail0      = head_reg + count_reg[RES_PTR_W-1:0];
    assign tail1      = tail0 + RES_PTR_W'(1);
    assign head_next  = head_reg + RES_PTR_W'(pop);
    assign count_next = count_reg + RES_CNT_W'(push.cnt) - RES_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            slot_reg[tail0] <= push.res0;
        end
        if (push.cnt == 2'd2)
        begin
            slot_reg[tail1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    `MMKE_ASSERT_IMPLY(a_push_has_room, clk, rst_n, push.cnt != 2'd0, count_reg <= 3'(RES_DEPTH - 2), "results pushed into a queue without room")
    `MMKE_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= 3'(RES_DEPTH), "result queue overflow")

endmodule

`default_nettype wire

>>> sv/msgpack_map_key_extractor_core.sv
// MessagePack map key extractor. The block takes one byte of a MessagePack
// buffer per request on the input channel and accepts a new byte in every
// cycle that in_stall is low; the parser decides each byte in the cycle it
// is accepted, and its results pass through a four-entry result queue to
// the output channel. A byte yields at most two results (a string value
// byte followed by a status), and the output channel delivers one result
// per cycle while out_stall is low, so sustained input rate is one byte per
// cycle as long as the consumer keeps up; the queue asserts stall on the
// input when fewer than two entries are free. Each buffer gets exactly one
// status result (found, key not found or malformed) with final_of_run set.
// In string mode the value bytes stream out as they arrive, so a consumer
// must drop them if the buffer closes as malformed. After the status, bytes
// are ignored up to and including the byte marked end_of_buffer.
// Configuration registers are written through a plain write port and should
// only change while the block is idle. There is no clearing pass after reset.
`default_nettype none

module msgpack_map_key_extractor_core #(
    parameter int unsigned KEY_MAX_BYTES = mmke_pkg::KEY_MAX_BYTES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Configuration write port.
    input  wire logic                                 cfg_write_en,
    input  wire logic [mmke_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [mmke_pkg::KEY_REG_W-1:0]       cfg_data,
    // Input channel.
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [7:0]                           in_byte,
    input  wire logic                                 end_of_buffer,
    // Output channel.
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [1:0]                                kind,
    output logic [mmke_pkg::PAYLOAD_W-1:0]            payload,
    output logic                                      final_of_run
);

    import mmke_pkg::*;

    logic [KEY_LEN_W-1:0] key_length_reg;
    logic [KEY_BITS-1:0]  key_bits_reg;
    logic                 want_string_reg;
    logic                 accept;
    push_t                push;
    res_t                 head;

    // Configuration registers. Writes to indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg  <= '0;
            key_bits_reg    <= '0;
            want_string_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_KEY_LENGTH:  key_length_reg <= cfg_data[KEY_LEN_W-1:0];
                CFG_KEY_BYTES_0: key_bits_reg[0*KEY_REG_W +: KEY_REG_W] <= cfg_data;
                CFG_KEY_BYTES_1: key_bits_reg[1*KEY_REG_W +: KEY_REG_W] <= cfg_data;
                CFG_KEY_BYTES_2: key_bits_reg[2*KEY_REG_W +: KEY_REG_W] <= cfg_data;
                CFG_KEY_BYTES_3: key_bits_reg[3*KEY_REG_W +: KEY_REG_W] <= cfg_data;
                CFG_WANT_STRING: want_string_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // A request is taken when valid is high and the queue has room.
    assign accept = in_valid && !in_stall;

    mmke_parser #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_buffer (end_of_buffer),
        .key_length    (key_length_reg),
        .key_bits      (key_bits_reg),
        .want_string   (want_string_reg),
        .push          (push)
    );

    mmke_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    // Every result other than a string byte is the closing status.
    assign kind         = head.kind;
    assign payload      = head.payload;
    assign final_of_run = head.kind != KIND_BYTE;

endmodule

`default_nettype wire

>>> tb/mmke_lookup_check_pkg.sv
// Scoreboard for the MessagePack map key extractor: a byte-level model of the
// map walk and the queue of answers it predicts. Depends on mmke_pkg.
package mmke_lookup_check_pkg;

    import mmke_pkg::*;

    typedef enum logic [3:0] {
        WALK_MAP_HDR, WALK_MAP_HI, WALK_MAP_LO,
        WALK_KEY_HDR, WALK_KEY_LEN8, WALK_KEY_HI, WALK_KEY_LO, WALK_KEY_BODY,
        WALK_VAL_HDR, WALK_VAL_INT, WALK_VAL_LEN8, WALK_VAL_HI, WALK_VAL_LO,
        WALK_STR_OUT, WALK_SKIP
    } walk_phase_t;

    typedef struct {
        kind_t       kind;
        logic [63:0] payload;
        logic        final_of_run;
    } answer_t;

    class lookup_scoreboard;
        logic [5:0]  key_len;
        logic [63:0] key_word [4];
        logic        want_str;

        walk_phase_t phase;
        logic [15:0] pairs_left;
        logic [15:0] bytes_left;
        logic [15:0] key_pos;
        logic        key_hit;
        logic [63:0] acc;
        logic        decided;

        answer_t     pending_answers [$];
        int          mismatches;

        function new();
            key_len = '0;
            foreach (key_word[i]) key_word[i] = '0;
            want_str = 1'b0;
            mismatches = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            phase = WALK_MAP_HDR;
            pairs_left = '0;
            bytes_left = '0;
            key_pos = '0;
            key_hit = 1'b0;
            acc = '0;
            decided = 1'b0;
        endfunction

        function void load_register(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
            if (idx == CFG_KEY_LENGTH)
                key_len = data[5:0];
            else if (idx >= CFG_KEY_BYTES_0 && idx <= CFG_KEY_BYTES_3)
                key_word[idx - CFG_KEY_BYTES_0] = data;
            else if (idx == CFG_WANT_STRING)
                want_str = data[0];
        endfunction

        function void push(kind_t k, logic [63:0] p, logic fin);
            answer_t a;
            a.kind = k;
            a.payload = p;
            a.final_of_run = fin;
            pending_answers.push_back(a);
        endfunction

        function void give_status(kind_t k, logic [63:0] p);
            push(k, p, 1'b1);
            decided = 1'b1;
        endfunction

        function logic [7:0] key_byte(logic [15:0] pos);
            if (pos >= KEY_REG_BYTES)
                return 8'h00;
            return key_word[pos[4:3]][8*pos[2:0] +: 8];
        endfunction

        function void pair_done();
            pairs_left = pairs_left - 16'd1;
            if (pairs_left == 0)
                give_status(KIND_NOT_FOUND, '0);
            else
                phase = WALK_KEY_HDR;
        endfunction

        function void start_key(logic [15:0] len);
            key_pos = '0;
            key_hit = (len == {10'd0, key_len}) && (len <= KEY_MAX_BYTES_DEF);
            bytes_left = len;
            if (len == 0)
                phase = WALK_VAL_HDR;
            else
                phase = WALK_KEY_BODY;
        endfunction

        function void start_string(logic [15:0] len);
            if (want_str && key_hit) begin
                if (len == 0) begin
                    give_status(KIND_FOUND, '0);
                end
                else begin
                    bytes_left = len;
                    phase = WALK_STR_OUT;
                end
            end
            else if (len == 0) begin
                pair_done();
            end
            else begin
                bytes_left = len;
                phase = WALK_SKIP;
            end
        endfunction

        function void start_int(logic [15:0] len);
            bytes_left = len;
            acc = '0;
            phase = WALK_VAL_INT;
        endfunction

        function void value_marker(logic [7:0] b);
            if (b <= 8'h7f) begin
                if (!want_str && key_hit)
                    give_status(KIND_FOUND, {56'd0, b});
                else
                    pair_done();
            end
            else if (b == MP_UINT8)  start_int(16'd1);
            else if (b == MP_UINT16) start_int(16'd2);
            else if (b == MP_UINT32) start_int(16'd4);
            else if (b == MP_UINT64) start_int(16'd8);
            else if (b[7:5] == MP_FIXSTR_HI) start_string({11'd0, b[4:0]});
            else if (b == MP_STR8)  phase = WALK_VAL_LEN8;
            else if (b == MP_STR16) phase = WALK_VAL_HI;
            else if (want_str && (b == MP_NIL || b == MP_FALSE || b == MP_TRUE))
                pair_done();
            else
                give_status(KIND_MALFORMED, '0);
        endfunction

        function void walk_byte(logic [7:0] b);
            case (phase)
                WALK_MAP_HDR: begin
                    if (b[7:4] == MP_FIXMAP_HI) begin
                        pairs_left = {12'd0, b[3:0]};
                        if (pairs_left == 0)
                            give_status(KIND_NOT_FOUND, '0);
                        else
                            phase = WALK_KEY_HDR;
                    end
                    else if (b == MP_MAP16) begin
                        phase = WALK_MAP_HI;
                    end
                    else begin
                        give_status(KIND_MALFORMED, '0);
                    end
                end
                WALK_MAP_HI: begin
                    pairs_left = {b, 8'h00};
                    phase = WALK_MAP_LO;
                end
                WALK_MAP_LO: begin
                    pairs_left = pairs_left | {8'h00, b};
                    if (pairs_left == 0)
                        give_status(KIND_NOT_FOUND, '0);
                    else
                        phase = WALK_KEY_HDR;
                end
                WALK_KEY_HDR: begin
                    if (b[7:5] == MP_FIXSTR_HI)
                        start_key({11'd0, b[4:0]});
                    else if (b == MP_STR8)
                        phase = WALK_KEY_LEN8;
                    else if (b == MP_STR16)
                        phase = WALK_KEY_HI;
                    else
                        give_status(KIND_MALFORMED, '0);
                end
                WALK_KEY_LEN8: start_key({8'h00, b});
                WALK_KEY_HI: begin
                    bytes_left = {b, 8'h00};
                    phase = WALK_KEY_LO;
                end
                WALK_KEY_LO: start_key(bytes_left | {8'h00, b});
                WALK_KEY_BODY: begin
                    if (key_hit && key_byte(key_pos) != b)
                        key_hit = 1'b0;
                    key_pos = key_pos + 16'd1;
                    bytes_left = bytes_left - 16'd1;
                    if (bytes_left == 0)
                        phase = WALK_VAL_HDR;
                end
                WALK_VAL_HDR: value_marker(b);
                WALK_VAL_INT: begin
                    acc = {acc[55:0], b};
                    bytes_left = bytes_left - 16'd1;
                    if (bytes_left == 0) begin
                        if (!want_str && key_hit)
                            give_status(KIND_FOUND, acc);
                        else
                            pair_done();
                    end
                end
                WALK_VAL_LEN8: start_string({8'h00, b});
                WALK_VAL_HI: begin
                    bytes_left = {b, 8'h00};
                    phase = WALK_VAL_LO;
                end
                WALK_VAL_LO: start_string(bytes_left | {8'h00, b});
                WALK_STR_OUT: begin
                    push(KIND_BYTE, {56'd0, b}, 1'b0);
                    bytes_left = bytes_left - 16'd1;
                    if (bytes_left == 0)
                        give_status(KIND_FOUND, '0);
                end
                WALK_SKIP: begin
                    bytes_left = bytes_left - 16'd1;
                    if (bytes_left == 0)
                        pair_done();
                end
                default: give_status(KIND_MALFORMED, '0);
            endcase
        endfunction

        // Returns 1 when the byte was parsed rather than ignored.
        function bit note_request(logic [7:0] b, logic last);
            bit parsed;
            parsed = !decided;
            if (!decided)
                walk_byte(b);
            if (last) begin
                if (!decided)
                    give_status(KIND_MALFORMED, '0);
                clear_walk();
            end
            return parsed;
        endfunction

        function void check_result(logic [1:0] k, logic [63:0] p, logic fin);
            answer_t a;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d payload %h final_of_run %b",
                             k, p, fin);
                return;
            end
            a = pending_answers.pop_front();
            if (k !== a.kind || p !== a.payload || fin !== a.final_of_run) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: kind %0d/%0d payload %h/%h final_of_run %b/%b",
                             a.kind, k, a.payload, p, a.final_of_run, fin);
            end
        endfunction

        function int outstanding();
            return pending_answers.size();
        endfunction
    endclass

endpackage

>>> tb/tb.sv
// Testbench top for msgpack_map_key_extractor_core: builds MessagePack map
// buffers, drives them byte by byte and checks every result against the
// scoreboard in mmke_lookup_check_pkg. Depends on mmke_pkg and that package.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmke_pkg::*;
    import mmke_lookup_check_pkg::*;

    logic clk;
    logic rst_n = 1'b0;

    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [63:0]            cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = '0;
    logic        end_of_buffer = 1'b0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [63:0] payload;
    logic        final_of_run;

    msgpack_map_key_extractor_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_of_buffer(end_of_buffer),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload      (payload),
        .final_of_run (final_of_run)
    );

    lookup_scoreboard sb = new();

    // Testbench copy of the configured key, used to build matching keys.
    logic [5:0]  cur_key_len;
    logic [63:0] cur_key [4];
    logic        cur_want_str;

    // The buffer being built, and the bookkeeping of the sender.
    logic [7:0] frame [$];
    int         sent_bytes = 0;
    int         burst_left = 0;

    // Receiver pattern state.
    int stall_mode = 0;
    int mode_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run. The slowest legal run is far below this.
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: every result accepted at an edge is checked against the oldest
    // expectation. The stall pattern switches at random among four modes:
    // no stall at all, light random stall, heavy random stall, or a toggle.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                sb.check_result(kind, payload, final_of_run);
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 60);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // Writes one register. The caller lowers the write enable after the last
    // write, so the enable never gets two assignments in one step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.load_register(idx, data);
        @(posedge clk);
    endtask

    // Loads the whole register set. Only called while the block is idle.
    task automatic configure_block(input logic [5:0] klen, input logic [63:0] w0,
                                   input logic [63:0] w1, input logic [63:0] w2,
                                   input logic [63:0] w3, input logic ws);
        cur_key_len = klen;
        cur_key[0] = w0;
        cur_key[1] = w1;
        cur_key[2] = w2;
        cur_key[3] = w3;
        cur_want_str = ws;
        write_reg(CFG_KEY_LENGTH, {58'd0, klen});
        write_reg(CFG_KEY_BYTES_0, w0);
        write_reg(CFG_KEY_BYTES_1, w1);
        write_reg(CFG_KEY_BYTES_2, w2);
        write_reg(CFG_KEY_BYTES_3, w3);
        write_reg(CFG_WANT_STRING, {63'd0, ws});
        cfg_write_en <= 1'b0;
    endtask

    // Presents one byte and holds it until a request is accepted. When 'more'
    // is set and no gap is due, valid stays high so the next request follows
    // back to back; otherwise valid drops in the same step as the acceptance.
    task automatic send_byte(input logic [7:0] b, input logic last, input bit more);
        int gap;
        in_valid <= 1'b1;
        in_byte <= b;
        end_of_buffer <= last;
        do @(posedge clk); while (in_stall);
        void'(sb.note_request(b, last));
        sent_bytes++;
        gap = 0;
        if (burst_left == 0)
        begin
            // Long bursts now and then give stretches with no idling at all.
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(40, 90);
            else
                burst_left = $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
        end
        else
        begin
            burst_left--;
        end
        if (gap != 0 || !more)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Sends the built buffer, with end_of_buffer on its final byte.
    task automatic send_frame(input bit end_of_phase);
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1,
                      !(end_of_phase && i == frame.size() - 1));
    endtask

    // Waits until every predicted result has come back, then waits further so
    // that a byte that causes no result has also left the parser.
    task automatic drain();
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Appends a string header for the given length in a random legal encoding.
    task automatic add_str_hdr(input int len);
        int r;
        r = $urandom_range(0, 2);
        if (len <= 31 && r == 0)
        begin
            frame.push_back({MP_FIXSTR_HI, 5'(len)});
        end
        else if (len <= 255 && r != 2)
        begin
            frame.push_back(MP_STR8);
            frame.push_back(8'(len));
        end
        else
        begin
            frame.push_back(MP_STR16);
            frame.push_back(8'(len >> 8));
            frame.push_back(8'(len));
        end
    endtask

    // Appends a key: the configured one, a near miss (one byte changed or the
    // length off by one), or an unrelated key, sometimes longer than any key
    // the block can hold.
    task automatic add_key(input bit hit);
        int  r;
        int  len;
        int  flip_at;
        bit  from_key;
        logic [7:0] b;
        r = hit ? 0 : $urandom_range(1, 4);
        len = cur_key_len;
        flip_at = -1;
        from_key = 1'b1;
        if (r == 1 && cur_key_len != 0)
        begin
            flip_at = $urandom_range(0, cur_key_len - 1);
        end
        else if (r == 2)
        begin
            if (cur_key_len != 0 && $urandom_range(0, 1) == 0)
                len = cur_key_len - 1;
            else
                len = cur_key_len + 1;
        end
        else if (r != 0)
        begin
            from_key = 1'b0;
            if ($urandom_range(0, 5) == 0)
                len = $urandom_range(30, 40);
            else
                len = $urandom_range(0, 8);
        end
        add_str_hdr(len);
        for (int i = 0; i < len; i++)
        begin
            if (from_key && i < 32)
                b = cur_key[i / 8][8 * (i % 8) +: 8];
            else
                b = 8'($urandom);
            if (i == flip_at)
                b = b ^ 8'($urandom_range(1, 255));
            frame.push_back(b);
        end
    endtask

    // Appends one value of any kind the format allows, plus the odd marker
    // that is not a legal value at all.
    task automatic add_value();
        int r;
        int n;
        int fill;
        int len;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 18)
        begin
            frame.push_back(8'($urandom_range(0, 127)));
        end
        else if (r < 55)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    frame.push_back(MP_UINT8);
                    n = 1;
                end
                1:
                begin
                    frame.push_back(MP_UINT16);
                    n = 2;
                end
                2:
                begin
                    frame.push_back(MP_UINT32);
                    n = 4;
                end
                default:
                begin
                    frame.push_back(MP_UINT64);
                    n = 8;
                end
            endcase
            fill = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                frame.push_back(fill == 0 ? 8'h00 : fill == 1 ? 8'hff : 8'($urandom));
        end
        else if (r < 88)
        begin
            if ($urandom_range(0, 149) == 0)
                len = $urandom_range(256, 300);
            else if ($urandom_range(0, 4) == 0)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(0, 12);
            add_str_hdr(len);
            for (int i = 0; i < len; i++)
                frame.push_back(8'($urandom));
        end
        else if (r < 95)
        begin
            case ($urandom_range(0, 2))
                0: frame.push_back(MP_NIL);
                1: frame.push_back(MP_FALSE);
                default: frame.push_back(MP_TRUE);
            endcase
        end
        else
        begin
            do b = 8'($urandom_range(128, 255));
            while (b inside {MP_UINT8, MP_UINT16, MP_UINT32, MP_UINT64, MP_STR8,
                             MP_STR16, MP_NIL, MP_FALSE, MP_TRUE}
                   || b[7:5] == MP_FIXSTR_HI);
            frame.push_back(b);
        end
    endtask

    // Builds one buffer. Most are well-formed maps with random content, where
    // the configured key may appear at any position, now and then twice. The
    // rest are cut short, have a byte overwritten, carry trailing bytes past
    // the answer, claim a random map16 pair count, or are plain noise.
    task automatic build_frame();
        int npairs;
        int hit_at;
        int r;
        int keep;
        frame.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
        end
        else
        begin
            if ($urandom_range(0, 7) == 0)
                npairs = $urandom_range(5, 15);
            else
                npairs = $urandom_range(0, 3);
            hit_at = $urandom_range(0, npairs);
            r = $urandom_range(0, 19);
            if (r == 0)
            begin
                frame.push_back(MP_MAP16);
                frame.push_back(8'($urandom));
                frame.push_back(8'($urandom));
            end
            else if (r < 4)
            begin
                frame.push_back(MP_MAP16);
                frame.push_back(8'h00);
                frame.push_back(8'(npairs));
            end
            else
            begin
                frame.push_back({MP_FIXMAP_HI, 4'(npairs)});
            end
            for (int i = 0; i < npairs; i++)
            begin
                add_key(i == hit_at || $urandom_range(0, 9) == 0);
                add_value();
            end
            r = $urandom_range(0, 99);
            if (r < 10 && frame.size() > 1)
            begin
                keep = $urandom_range(1, frame.size() - 1);
                while (frame.size() > keep) frame.pop_back();
            end
            else if (r < 18)
            begin
                frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
            end
            else if (r < 28)
            begin
                repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom));
            end
        end
    endtask

    initial
    begin
        int nframes;
        int phase_no;
        logic [5:0] klen;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, uint mode, one-byte key "a".
        configure_block(6'd1, 64'h61, '0, '0, '0, 1'b0);
        // Empty fixmap answers not found right after the header.
        frame = {8'h80};
        send_frame(1'b0);
        // Matching key with the largest fixint.
        frame = {8'h81, 8'ha1, 8'h61, 8'h7f};
        send_frame(1'b0);
        // A header byte that is no map at all.
        frame = {8'hff};
        send_frame(1'b0);
        // Buffer cut short inside the first key.
        frame = {8'h81, 8'ha1};
        send_frame(1'b0);
        // Nil under the matching key is malformed in uint mode.
        frame = {8'h81, 8'ha1, 8'h61, MP_NIL};
        send_frame(1'b0);
        // Bytes after the answer are ignored up to the end of the buffer.
        frame = {8'h80, 8'h00};
        send_frame(1'b0);
        // map16 with no pairs.
        frame = {MP_MAP16, 8'h00, 8'h00};
        send_frame(1'b1);
        drain();

        // Directed part, string mode.
        configure_block(6'd1, 64'h61, '0, '0, '0, 1'b1);
        // An empty matching string answers found with no value bytes.
        frame = {8'h81, 8'ha1, 8'h61, 8'ha0};
        send_frame(1'b0);
        // One value byte, then found.
        frame = {8'h81, 8'ha1, 8'h61, 8'ha1, 8'h41};
        send_frame(1'b1);
        drain();

        // Random part. Each phase picks a register setting, sends a handful of
        // buffers and then waits until every result is back before the next
        // setting is written. The first two phases use the extremes.
        phase_no = 0;
        while (sent_bytes < 800)
        begin
            if (phase_no == 0)
            begin
                configure_block(6'd0, '0, '0, '0, '0, 1'b0);
            end
            else if (phase_no == 1)
            begin
                configure_block(6'd32, '1, '1, '1, '1, 1'b1);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: klen = 6'd32;
                    1: klen = 6'($urandom_range(0, 3));
                    default: klen = 6'($urandom_range(1, 31));
                endcase
                configure_block(klen, {$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom}, {$urandom, $urandom},
                                1'($urandom_range(0, 1)));
            end
            nframes = $urandom_range(4, 8);
            for (int f = 0; f < nframes; f++)
            begin
                build_frame();
                send_frame(f == nframes - 1);
            end
            drain();
            phase_no++;
        end

        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
